// ===== hdl/pmpt_pkg.sv =====
package pmpt_pkg;

  localparam int unsigned PosWidth   = 12;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned CellXWidth = 9;
  localparam int unsigned CellYWidth = 8;
  localparam int unsigned BtnWidth   = 3;
  localparam int unsigned CfgIdxWidth = 2;

  localparam int unsigned CellWidthShift  = 3;
  localparam int unsigned CellHeightShift = 4;

  localparam logic [PosWidth-1:0] MaxPixelXReset = 12'd639;
  localparam logic [PosWidth-1:0] MaxPixelYReset = 12'd399;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxWidth-1:0] CfgMaxPixelX = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgMaxPixelY = 2'd1;

  // Position of the next byte within a packet.
  typedef enum logic [1:0] {
    PHASE_HEADER = 2'd0,
    PHASE_X      = 2'd1,
    PHASE_Y      = 2'd2
  } phase_e;

  typedef logic [PosWidth-1:0] pos_t;

  // Sums are carried two bits wider than a position so that both an
  // underflow below zero and an overflow past 4095 stay visible.
  typedef logic signed [PosWidth+1:0] sum_t;

  function automatic pos_t clamp_pos(sum_t v, pos_t maxv);
    sum_t max_ext;
    pos_t r;
    max_ext = sum_t'({2'b00, maxv});
    if (v < 0) begin
      r = '0;
    end else if (v >= max_ext) begin
      r = maxv;
    end else begin
      r = v[PosWidth-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/ps2_mouse_packet_tracker_unit.sv =====
// Groups received mouse bytes into three-byte packets (header, X movement,
// Y movement) and tracks a clamped pointer position. On the third byte of
// each packet one result is produced with the pixel position, the text cell
// (pixel X over 8, pixel Y over 16) and the three button bits of the header;
// the first two bytes of a packet produce nothing. Bytes are counted in
// threes from reset with no sync check. The block takes one byte per cycle:
// the add and clamp sit between the input handshake and a single result
// register, and a new byte is taken whenever that register is empty or is
// being emptied in the same cycle. A result appears in the cycle after its
// third byte is transferred. Maximum registers may be written at any idle
// time and take effect at the next completed packet.
module ps2_mouse_packet_tracker_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [pmpt_pkg::CfgIdxWidth-1:0]       cfg_index_i,
  input  logic [pmpt_pkg::PosWidth-1:0]          cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [pmpt_pkg::ByteWidth-1:0]         rx_byte_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [pmpt_pkg::PosWidth-1:0]          pixel_x_o,
  output logic [pmpt_pkg::PosWidth-1:0]          pixel_y_o,
  output logic [pmpt_pkg::CellXWidth-1:0]        cell_x_o,
  output logic [pmpt_pkg::CellYWidth-1:0]        cell_y_o,
  output logic [pmpt_pkg::BtnWidth-1:0]          button_bits_o
);

  pmpt_pkg::phase_e phase_q, phase_d;
  logic [pmpt_pkg::ByteWidth-1:0] header_q, header_d;
  logic [pmpt_pkg::ByteWidth-1:0] xdelta_q, xdelta_d;
  pmpt_pkg::pos_t pos_x_q, pos_x_d;
  pmpt_pkg::pos_t pos_y_q, pos_y_d;
  pmpt_pkg::pos_t max_x_q, max_x_d;
  pmpt_pkg::pos_t max_y_q, max_y_d;

  logic out_valid_q, out_valid_d;
  pmpt_pkg::pos_t res_x_q, res_x_d;
  pmpt_pkg::pos_t res_y_q, res_y_d;
  logic [pmpt_pkg::BtnWidth-1:0] res_btn_q, res_btn_d;

  logic in_fire;
  logic last_byte;
  pmpt_pkg::sum_t sum_x;
  pmpt_pkg::sum_t sum_y;
  pmpt_pkg::pos_t shift_x;
  pmpt_pkg::pos_t shift_y;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  // Anything other than the header or X phases completes a packet.
  assign last_byte   = (phase_q != pmpt_pkg::PHASE_HEADER) && (phase_q != pmpt_pkg::PHASE_X);

  assign sum_x = pmpt_pkg::sum_t'({2'b00, pos_x_q})
               + pmpt_pkg::sum_t'($signed(xdelta_q));
  assign sum_y = pmpt_pkg::sum_t'({2'b00, pos_y_q})
               - pmpt_pkg::sum_t'($signed(rx_byte_i));

  always_comb begin
    max_x_d = max_x_q;
    max_y_d = max_y_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        pmpt_pkg::CfgMaxPixelX: max_x_d = cfg_data_i;
        pmpt_pkg::CfgMaxPixelY: max_y_d = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    phase_d     = phase_q;
    header_d    = header_q;
    xdelta_d    = xdelta_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    res_x_d     = res_x_q;
    res_y_d     = res_y_q;
    res_btn_d   = res_btn_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (in_fire) begin
      case (phase_q)
        pmpt_pkg::PHASE_HEADER: begin
          header_d = rx_byte_i;
          phase_d  = pmpt_pkg::PHASE_X;
        end
        pmpt_pkg::PHASE_X: begin
          xdelta_d = rx_byte_i;
          phase_d  = pmpt_pkg::PHASE_Y;
        end
        default: begin
          pos_x_d     = pmpt_pkg::clamp_pos(sum_x, max_x_q);
          pos_y_d     = pmpt_pkg::clamp_pos(sum_y, max_y_q);
          res_x_d     = pos_x_d;
          res_y_d     = pos_y_d;
          res_btn_d   = header_q[pmpt_pkg::BtnWidth-1:0];
          out_valid_d = 1'b1;
          phase_d     = pmpt_pkg::PHASE_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= pmpt_pkg::PHASE_HEADER;
      header_q    <= '0;
      xdelta_q    <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      max_x_q     <= pmpt_pkg::MaxPixelXReset;
      max_y_q     <= pmpt_pkg::MaxPixelYReset;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      header_q    <= header_d;
      xdelta_q    <= xdelta_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      max_x_q     <= max_x_d;
      max_y_q     <= max_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_x_q   <= res_x_d;
    res_y_q   <= res_y_d;
    res_btn_q <= res_btn_d;
  end

  assign shift_x = res_x_q >> pmpt_pkg::CellWidthShift;
  assign shift_y = res_y_q >> pmpt_pkg::CellHeightShift;

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = res_x_q;
  assign pixel_y_o     = res_y_q;
  assign cell_x_o      = shift_x[pmpt_pkg::CellXWidth-1:0];
  assign cell_y_o      = shift_y[pmpt_pkg::CellYWidth-1:0];
  assign button_bits_o = res_btn_q;

  // A completed packet always leaves its new position in the result register.
  a_result_after_packet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_byte) |=> (out_valid_q && res_x_q == pos_x_q && res_y_q == pos_y_q))
    else $error("result register does not match the tracked position");

  // The first two bytes of a packet never move the pointer.
  a_position_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !last_byte) |=> ($stable(pos_x_q) && $stable(pos_y_q)))
    else $error("position changed on a header or X byte");

  // The byte counter advances only on an input transfer.
  a_phase_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(phase_q))
    else $error("packet phase changed without an input transfer");

endmodule
